### src/hsv_to_rgb_converter_defines.svh
// Assertion macros used by hsv2rgb_ctrl.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)
`endif

`endif

### src/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

    localparam int HUE_W      = 15;
    localparam int SV_W       = 9;
    localparam int CH_W       = 8;
    localparam int REM_W      = 12;
    localparam int ONE_Q8     = 256;
    localparam int SEXT_DIV   = 15;   // sextant width 3840 = 15 << 8
    localparam int NUM_STAGES = 5;

    typedef enum logic [2:0] {
        SEXT_RED_YEL = 3'd0,
        SEXT_YEL_GRN = 3'd1,
        SEXT_GRN_CYN = 3'd2,
        SEXT_CYN_BLU = 3'd3,
        SEXT_BLU_MAG = 3'd4,
        SEXT_MAG_RED = 3'd5
    } sextant_t;

    // floor(hi / 15) for hi = hue >> 8, result 0..8
    function automatic logic [3:0] sext_of_hi(input logic [6:0] hi);
        logic [3:0] n;
        n = '0;
        for (int k = 1; k <= 8; k++) begin
            if (hi >= 7'(SEXT_DIV * k)) begin
                n = n + 4'd1;
            end
        end
        return n;
    endfunction

endpackage

### src/hsv2rgb_ctrl.sv
`include "hsv_to_rgb_converter_defines.svh"

module hsv2rgb_ctrl
    import hsv2rgb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [NUM_STAGES-1:0] load
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_comb begin
        valid_next[0] = load[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            valid_next[i] = load[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = load[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];

    `ASSERT_PROP(a_empty_after_reset, aclk, aresetn, $rose(aresetn) |-> (valid_reg == '0))
    `ASSERT_PROP(a_stalled_beat_kept, aclk, aresetn, 1'b1 |=> ((valid_reg & ~$past(load)) == ($past(valid_reg) & ~$past(load))))
    `ASSERT_NEVER(a_ready_when_drained, aclk, aresetn, !valid_reg[NUM_STAGES-1] && !(&load))

endmodule

### src/hsv2rgb_split.sv
module hsv2rgb_split
    import hsv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                 aclk,
    input  logic [1:0]           load,
    input  logic [HUE_W-1:0]     hue,
    input  logic [SV_W-1:0]      saturation,
    input  logic [SV_W-1:0]      brightness,
    output sextant_t             sext,
    output logic [FRAC_BITS-1:0] frac,
    output logic [SV_W-1:0]      sat,
    output logic [SV_W-1:0]      val
);

    localparam int YW = FRAC_BITS + 4;
    localparam int K  = FRAC_BITS + 8;
    localparam int MW = K - 3;
    localparam int PW = YW + MW;
    localparam logic [MW-1:0] RECIP = MW'((2**K + SEXT_DIV - 1) / SEXT_DIV);
    localparam logic [SV_W-1:0] ONE_SV = SV_W'(ONE_Q8);

    logic [6:0]       hue_hi;
    logic [3:0]       sext_raw;
    logic [6:0]       rem_hi;
    sextant_t         s0_sext_next;
    logic [REM_W-1:0] s0_rem_next;
    logic [SV_W-1:0]  s0_sat_next;
    logic [SV_W-1:0]  s0_val_next;

    sextant_t         s0_sext_reg;
    logic [REM_W-1:0] s0_rem_reg;
    logic [SV_W-1:0]  s0_sat_reg;
    logic [SV_W-1:0]  s0_val_reg;

    logic [REM_W+FRAC_BITS-1:0] rem_wide;
    logic [YW-1:0]              y;
    logic [PW-1:0]              prod;
    logic [FRAC_BITS-1:0]       s1_frac_next;

    sextant_t             s1_sext_reg;
    logic [FRAC_BITS-1:0] s1_frac_reg;
    logic [SV_W-1:0]      s1_sat_reg;
    logic [SV_W-1:0]      s1_val_reg;

    // stage 0: sextant, remainder, clamp
    always_comb begin
        hue_hi   = hue[HUE_W-1:8];
        sext_raw = sext_of_hi(hue_hi);
        rem_hi   = hue_hi - 7'(SEXT_DIV * int'(sext_raw));
        s0_rem_next = {rem_hi[3:0], hue[7:0]};
        if (sext_raw >= 4'd6) begin
            s0_sext_next = sextant_t'(3'(sext_raw - 4'd6));
        end else begin
            s0_sext_next = sextant_t'(sext_raw[2:0]);
        end
        s0_sat_next = saturation[SV_W-1] ? ONE_SV : saturation;
        s0_val_next = brightness[SV_W-1] ? ONE_SV : brightness;
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            s0_sext_reg <= s0_sext_next;
            s0_rem_reg  <= s0_rem_next;
            s0_sat_reg  <= s0_sat_next;
            s0_val_reg  <= s0_val_next;
        end
    end

    // stage 1: f = floor(rem * 2^F / 3840) by reciprocal of 15
    always_comb begin
        rem_wide     = {s0_rem_reg, {FRAC_BITS{1'b0}}};
        y            = rem_wide[REM_W+FRAC_BITS-1:8];
        prod         = PW'(y) * PW'(RECIP);
        s1_frac_next = prod[K+FRAC_BITS-1:K];
    end

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            s1_sext_reg <= s0_sext_reg;
            s1_frac_reg <= s1_frac_next;
            s1_sat_reg  <= s0_sat_reg;
            s1_val_reg  <= s0_val_reg;
        end
    end

    assign sext = s1_sext_reg;
    assign frac = s1_frac_reg;
    assign sat  = s1_sat_reg;
    assign val  = s1_val_reg;

endmodule

### src/hsv2rgb_comp.sv
module hsv2rgb_comp
    import hsv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                      aclk,
    input  logic [1:0]                load,
    input  sextant_t                  sext_in,
    input  logic [FRAC_BITS-1:0]      frac,
    input  logic [SV_W-1:0]           sat,
    input  logic [SV_W-1:0]           val_in,
    output sextant_t                  sext_out,
    output logic [SV_W-1:0]           val_out,
    output logic [FRAC_BITS+17:0]     p_prod,
    output logic [FRAC_BITS+17:0]     q_prod,
    output logic [FRAC_BITS+17:0]     t_prod
);

    localparam int BW = FRAC_BITS + 9;
    localparam int AW = BW + 9;
    localparam logic [BW-1:0]        ONE_B  = BW'(ONE_Q8) << FRAC_BITS;
    localparam logic [FRAC_BITS:0]   ONE_F  = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam logic [SV_W-1:0]      ONE_SV = SV_W'(ONE_Q8);

    logic [BW-1:0]      fs_prod;
    logic [FRAC_BITS:0] one_minus_f;
    logic [BW:0]        gs_prod;
    logic [BW-1:0]      p_b_next;
    logic [BW-1:0]      q_b_next;
    logic [BW-1:0]      t_b_next;

    sextant_t          s2_sext_reg;
    logic [SV_W-1:0]   s2_val_reg;
    logic [BW-1:0]     p_b_reg;
    logic [BW-1:0]     q_b_reg;
    logic [BW-1:0]     t_b_reg;

    sextant_t          s3_sext_reg;
    logic [SV_W-1:0]   s3_val_reg;
    logic [AW-1:0]     p_a_reg;
    logic [AW-1:0]     q_a_reg;
    logic [AW-1:0]     t_a_reg;

    // stage 2: (1-s), (1-fs), (1-(1-f)s), all with 8+F fraction bits
    always_comb begin
        fs_prod     = BW'(frac) * BW'(sat);
        one_minus_f = ONE_F - {1'b0, frac};
        gs_prod     = (BW+1)'(one_minus_f) * (BW+1)'(sat);
        p_b_next    = {ONE_SV - sat, {FRAC_BITS{1'b0}}};
        q_b_next    = ONE_B - fs_prod;
        t_b_next    = ONE_B - gs_prod[BW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            s2_sext_reg <= sext_in;
            s2_val_reg  <= val_in;
            p_b_reg     <= p_b_next;
            q_b_reg     <= q_b_next;
            t_b_reg     <= t_b_next;
        end
    end

    // stage 3: scale by v
    always_ff @(posedge aclk) begin
        if (load[1]) begin
            s3_sext_reg <= s2_sext_reg;
            s3_val_reg  <= s2_val_reg;
            p_a_reg     <= AW'(s2_val_reg) * AW'(p_b_reg);
            q_a_reg     <= AW'(s2_val_reg) * AW'(q_b_reg);
            t_a_reg     <= AW'(s2_val_reg) * AW'(t_b_reg);
        end
    end

    assign sext_out = s3_sext_reg;
    assign val_out  = s3_val_reg;
    assign p_prod   = p_a_reg;
    assign q_prod   = q_a_reg;
    assign t_prod   = t_a_reg;

endmodule

### src/hsv2rgb_mix.sv
module hsv2rgb_mix
    import hsv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  load,
    input  sextant_t              sext,
    input  logic [SV_W-1:0]       val,
    input  logic [FRAC_BITS+17:0] p_prod,
    input  logic [FRAC_BITS+17:0] q_prod,
    input  logic [FRAC_BITS+17:0] t_prod,
    output logic [CH_W-1:0]       red,
    output logic [CH_W-1:0]       green,
    output logic [CH_W-1:0]       blue
);

    localparam int AW    = FRAC_BITS + 18;
    localparam int SHIFT = FRAC_BITS + 16;

    // floor(a * 255 / 2^SHIFT), low byte
    function automatic logic [CH_W-1:0] scale255(input logic [AW-1:0] a);
        logic [AW+7:0] wide;
        wide = {a, 8'b0} - (AW+8)'(a);
        return wide[SHIFT+CH_W-1:SHIFT];
    endfunction

    logic [SV_W+7:0]  v_wide;
    logic [CH_W-1:0]  vc;
    logic [CH_W-1:0]  pc;
    logic [CH_W-1:0]  qc;
    logic [CH_W-1:0]  tc;
    logic [CH_W-1:0]  red_next;
    logic [CH_W-1:0]  green_next;
    logic [CH_W-1:0]  blue_next;
    logic [CH_W-1:0]  red_reg;
    logic [CH_W-1:0]  green_reg;
    logic [CH_W-1:0]  blue_reg;

    always_comb begin
        v_wide = {val, 8'b0} - (SV_W+8)'(val);
        vc     = v_wide[15:8];
        pc     = scale255(p_prod);
        qc     = scale255(q_prod);
        tc     = scale255(t_prod);
        unique case (sext)
            SEXT_RED_YEL: begin red_next = vc; green_next = tc; blue_next = pc; end
            SEXT_YEL_GRN: begin red_next = qc; green_next = vc; blue_next = pc; end
            SEXT_GRN_CYN: begin red_next = pc; green_next = vc; blue_next = tc; end
            SEXT_CYN_BLU: begin red_next = pc; green_next = qc; blue_next = vc; end
            SEXT_BLU_MAG: begin red_next = tc; green_next = pc; blue_next = vc; end
            SEXT_MAG_RED: begin red_next = vc; green_next = pc; blue_next = qc; end
            default:      begin red_next = vc; green_next = pc; blue_next = qc; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

### src/hsv_to_rgb_converter.sv
// channel | dir | fields (tdata, lsb first)
// s_      | in  | hue[14:0], saturation[23:15], brightness[32:24], zero pad to 40
// m_      | out | red[7:0], green[15:8], blue[23:16]
//
// Five register stages; one beat per cycle sustained while m_tready is held high.
// Stages: sextant split, fraction multiply, 1-x terms, v multiply, x255 and mux.
// aresetn clears only the stage valid bits; payload registers are not reset.
// Each stage loads when empty or draining, so bubbles collapse on a stall.
module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // hue[14:0], saturation[23:15], brightness[32:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

    logic [NUM_STAGES-1:0] load;

    sextant_t              split_sext;
    logic [FRAC_BITS-1:0]  split_frac;
    logic [SV_W-1:0]       split_sat;
    logic [SV_W-1:0]       split_val;

    sextant_t              comp_sext;
    logic [SV_W-1:0]       comp_val;
    logic [FRAC_BITS+17:0] p_prod;
    logic [FRAC_BITS+17:0] q_prod;
    logic [FRAC_BITS+17:0] t_prod;

    logic [CH_W-1:0]       red;
    logic [CH_W-1:0]       green;
    logic [CH_W-1:0]       blue;

    hsv2rgb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .load     (load)
    );

    hsv2rgb_split #(
        .FRAC_BITS (FRAC_BITS)
    ) u_split (
        .aclk       (aclk),
        .load       (load[1:0]),
        .hue        (s_tdata[14:0]),
        .saturation (s_tdata[23:15]),
        .brightness (s_tdata[32:24]),
        .sext       (split_sext),
        .frac       (split_frac),
        .sat        (split_sat),
        .val        (split_val)
    );

    hsv2rgb_comp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_comp (
        .aclk     (aclk),
        .load     (load[3:2]),
        .sext_in  (split_sext),
        .frac     (split_frac),
        .sat      (split_sat),
        .val_in   (split_val),
        .sext_out (comp_sext),
        .val_out  (comp_val),
        .p_prod   (p_prod),
        .q_prod   (q_prod),
        .t_prod   (t_prod)
    );

    hsv2rgb_mix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mix (
        .aclk   (aclk),
        .load   (load[4]),
        .sext   (comp_sext),
        .val    (comp_val),
        .p_prod (p_prod),
        .q_prod (q_prod),
        .t_prod (t_prod),
        .red    (red),
        .green  (green),
        .blue   (blue)
    );

    assign m_tdata = {blue, green, red};

endmodule

### tb/sv/rgb_pixel_checker.sv
module rgb_pixel_checker
    import hsv2rgb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // hue[14:0], saturation[23:15], brightness[32:24]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // red[7:0], green[15:8], blue[23:16]
    output int          err_count,
    output int          pending
);

    localparam int FRAC        = 8;
    localparam int SEXT_UNITS  = 3840;
    localparam int NUM_SEXT    = 6;
    localparam int CH_SCALE    = 255;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    rgb_t rgb_expected[$];

    function automatic logic [CH_W-1:0] scale_chan(input longint unsigned num);
        return CH_W'((num * CH_SCALE) >> (16 + FRAC));
    endfunction

    function automatic rgb_t hsv_to_rgb_pixel(input logic [HUE_W-1:0] hue,
                                              input logic [SV_W-1:0]  sat_in,
                                              input logic [SV_W-1:0]  val_in);
        longint unsigned s, v, rem, fq, one_f;
        logic [CH_W-1:0] vc, pc, qc, tc;
        sextant_t        sext;
        rgb_t            px;
        s     = (sat_in > ONE_Q8) ? ONE_Q8 : sat_in;
        v     = (val_in > ONE_Q8) ? ONE_Q8 : val_in;
        sext  = sextant_t'((hue / SEXT_UNITS) % NUM_SEXT);
        rem   = hue % SEXT_UNITS;
        fq    = (rem << FRAC) / SEXT_UNITS;
        one_f = longint'(1) << FRAC;
        vc    = scale_chan((v * ONE_Q8) << FRAC);
        pc    = scale_chan((v * (ONE_Q8 - s)) << FRAC);
        qc    = scale_chan(v * ((ONE_Q8 << FRAC) - fq * s));
        tc    = scale_chan(v * ((ONE_Q8 << FRAC) - (one_f - fq) * s));
        case (sext)
            SEXT_RED_YEL: px = '{red: vc, green: tc, blue: pc};
            SEXT_YEL_GRN: px = '{red: qc, green: vc, blue: pc};
            SEXT_GRN_CYN: px = '{red: pc, green: vc, blue: tc};
            SEXT_CYN_BLU: px = '{red: pc, green: qc, blue: vc};
            SEXT_BLU_MAG: px = '{red: tc, green: pc, blue: vc};
            default:      px = '{red: vc, green: pc, blue: qc};
        endcase
        return px;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    always @(posedge aclk) begin
        rgb_t got, want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                rgb_expected.push_back(hsv_to_rgb_pixel(s_tdata[14:0], s_tdata[23:15],
                                                        s_tdata[32:24]));
            end
            if (m_tvalid && m_tready) begin
                got = '{red: m_tdata[7:0], green: m_tdata[15:8], blue: m_tdata[23:16]};
                if (rgb_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat rgb=%h", got));
                end else begin
                    want = rgb_expected.pop_front();
                    if (got.red !== want.red)
                        report_mismatch($sformatf("red got %0d exp %0d",
                                                  got.red, want.red));
                    if (got.green !== want.green)
                        report_mismatch($sformatf("green got %0d exp %0d",
                                                  got.green, want.green));
                    if (got.blue !== want.blue)
                        report_mismatch($sformatf("blue got %0d exp %0d",
                                                  got.blue, want.blue));
                end
            end
            pending <= rgb_expected.size();
        end
    end

endmodule

### tb/sv/testbench.sv
module testbench;
    import hsv2rgb_pkg::*;

    localparam int NUM_RANDOM = 1250;
    localparam int SEXT_UNITS = 3840;
    localparam int HUE_TOP    = 23039;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    int          err_count;
    int          pending;
    bit          calm     = 1'b0;

    hsv_to_rgb_converter u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rgb_pixel_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .err_count (err_count),
        .pending   (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(12 * 600_000);
        $display("*** FAILED ***");
        $finish;
    end

    // mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    task automatic send_pixel(input int hue, input int sat, input int val);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, SV_W'(val), SV_W'(sat), HUE_W'(hue)};
        do @(posedge aclk); while (!s_tready);
    endtask

    // result side back-pressure
    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            stall = idle_len();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    initial begin
        int sel;
        int k;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_pixel(0, 0, 0);
        send_pixel(0, 256, 256);
        send_pixel(HUE_TOP, 256, 256);
        send_pixel(15'h7fff, 9'h1ff, 9'h1ff);
        send_pixel(SEXT_UNITS - 1, 256, 256);
        send_pixel(SEXT_UNITS, 256, 256);
        send_pixel(15, 1, 256);
        send_pixel(1 * SEXT_UNITS + 1920, 200, 180);
        send_pixel(2 * SEXT_UNITS + 1920, 200, 180);
        send_pixel(3 * SEXT_UNITS + 1920, 200, 180);
        send_pixel(4 * SEXT_UNITS + 1920, 200, 180);
        send_pixel(5 * SEXT_UNITS + 1920, 200, 180);
        send_pixel(1920, 0, 200);
        send_pixel(10000, 0, 256);
        send_pixel(10000, 257, 100);
        send_pixel(10000, 100, 257);
        send_pixel(6 * SEXT_UNITS, 256, 256);
        send_pixel(7 * SEXT_UNITS + 100, 128, 255);
        send_pixel(8 * SEXT_UNITS + 3000, 255, 128);
        send_pixel(15'h5555, 9'h0aa, 9'h155);
        send_pixel(15'h2aaa, 9'h155, 9'h0aa);
        send_pixel(12345, 1, 1);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            calm = (i % 300) < 60;
            sel  = $urandom_range(0, 9);
            if (sel <= 5) begin
                send_pixel($urandom_range(0, HUE_TOP), $urandom_range(0, 256),
                           $urandom_range(0, 256));
            end else if (sel == 6) begin
                send_pixel($urandom, $urandom, $urandom);
            end else if (sel == 7) begin
                k = $urandom_range(0, 2);
                send_pixel($urandom, (k == 0) ? 0 : (k == 1) ? 256 : 511,
                           $urandom_range(0, 256));
            end else if (sel == 8) begin
                k = $urandom_range(0, 2);
                send_pixel($urandom, $urandom_range(0, 256),
                           (k == 0) ? 0 : (k == 1) ? 256 : 511);
            end else begin
                k = $urandom_range(0, 8);
                send_pixel(HUE_W'(k * SEXT_UNITS + $urandom_range(0, 4) - 2),
                           $urandom_range(0, 256), $urandom_range(0, 256));
            end
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        do @(posedge aclk); while (pending != 0);
        repeat (NUM_STAGES * 4) @(posedge aclk);
        if (err_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
